FILE: design/uoi_pkg.sv
// ---------------------------------------------------------------------------
// uoi_pkg: shared constants and types for the odometry integrator
// Fixed-point constants, CORDIC angle table and sequencer state type.
// ---------------------------------------------------------------------------
package uoi_pkg;

    localparam int CordicSteps = 16;
    localparam int StepW       = 5;

    localparam logic signed [19:0] HeadPi    = 20'sd205887;
    localparam logic signed [19:0] HeadTwoPi = 20'sd411775;
    localparam logic signed [27:0] AngPi     = 28'sd52707179;
    localparam logic signed [27:0] AngHalfPi = 28'sd26353589;
    localparam logic signed [31:0] CordicK   = 32'sd652032874;

    localparam logic [1:0] RegStartX  = 2'd0;
    localparam logic [1:0] RegStartY  = 2'd1;
    localparam logic [1:0] RegStartH  = 2'd2;

    localparam logic CmdVel  = 1'b0;
    localparam logic CmdTick = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD,
        ST_WRAP,
        ST_C1_INIT,
        ST_C1_RUN,
        ST_MUL_X,
        ST_MUL_Y,
        ST_C2_INIT,
        ST_C2_RUN,
        ST_OUT
    } state_t;

    function automatic logic signed [27:0] atan_lut(input logic [StepW-1:0] i);
        case (i)
            5'd0:  atan_lut = 28'sd13176795;
            5'd1:  atan_lut = 28'sd7778716;
            5'd2:  atan_lut = 28'sd4110060;
            5'd3:  atan_lut = 28'sd2086331;
            5'd4:  atan_lut = 28'sd1047214;
            5'd5:  atan_lut = 28'sd524117;
            5'd6:  atan_lut = 28'sd262123;
            5'd7:  atan_lut = 28'sd131069;
            5'd8:  atan_lut = 28'sd65536;
            5'd9:  atan_lut = 28'sd32768;
            5'd10: atan_lut = 28'sd16384;
            5'd11: atan_lut = 28'sd8192;
            5'd12: atan_lut = 28'sd4096;
            5'd13: atan_lut = 28'sd2048;
            5'd14: atan_lut = 28'sd1024;
            5'd15: atan_lut = 28'sd512;
            5'd16: atan_lut = 28'sd256;
            5'd17: atan_lut = 28'sd128;
            5'd18: atan_lut = 28'sd64;
            5'd19: atan_lut = 28'sd32;
            5'd20: atan_lut = 28'sd16;
            5'd21: atan_lut = 28'sd8;
            5'd22: atan_lut = 28'sd4;
            5'd23: atan_lut = 28'sd2;
            default: atan_lut = 28'sd0;
        endcase
    endfunction

endpackage

FILE: design/uoi_cordic.sv
// ---------------------------------------------------------------------------
// uoi_cordic: iterated rotation-mode CORDIC
// One micro-rotation per cycle; sine and cosine in Q2.30.
// ---------------------------------------------------------------------------
module uoi_cordic (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [27:0]  angle,
    output logic                done,
    output logic signed [31:0]  sin_out,
    output logic signed [31:0]  cos_out
);
    logic signed [31:0] x_reg, x_next, y_reg, y_next;
    logic signed [27:0] z_reg, z_next;
    logic [uoi_pkg::StepW-1:0] i_reg, i_next;
    logic busy_reg, busy_next;
    logic signed [31:0] xs, ys;

    always_comb begin
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        i_next = i_reg; busy_next = busy_reg;
        if (start) begin
            x_next = uoi_pkg::CordicK; y_next = '0; z_next = angle;
            i_next = '0; busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!z_reg[27]) begin
                x_next = x_reg - ys; y_next = y_reg + xs;
                z_next = z_reg - uoi_pkg::atan_lut(i_reg);
            end else begin
                x_next = x_reg + ys; y_next = y_reg - xs;
                z_next = z_reg + uoi_pkg::atan_lut(i_reg);
            end
            i_next = i_reg + 1'b1;
            if (i_reg == uoi_pkg::StepW'(uoi_pkg::CordicSteps - 1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            i_reg    <= i_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done    = !busy_reg && !start;
    assign sin_out = y_reg;
    assign cos_out = x_reg;

`ifndef SYNTHESIS
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> i_reg < uoi_pkg::StepW'(uoi_pkg::CordicSteps))
        else $error("cordic step out of range");
    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !start && i_reg == uoi_pkg::StepW'(uoi_pkg::CordicSteps - 1))
        |=> !busy_reg)
        else $error("cordic did not finish");
    a_start_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && i_reg == '0)
        else $error("cordic start not taken");
`endif
endmodule

FILE: design/unicycle_odometry_integrator_top.sv
// ---------------------------------------------------------------------------
// unicycle_odometry_integrator_top: dead-reckoning pose integrator
// Heading update and wrap, CORDIC sin/cos, position step, yaw quaternion.
// ---------------------------------------------------------------------------
// Sequence: a velocity word or the first tick gives no result word; a later
//   tick passes HEAD, WRAP (repeated for each 2*pi removed), the shared
//   CORDIC for sin/cos, MUL_X, MUL_Y for x then y, the CORDIC again and OUT.
// Throughput: one item at a time; the next word is taken after the result
//   word has been taken from the output register.
// Reset: synchronous, active low; loads default start values into the start registers and the pose.
module unicycle_odometry_integrator_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // lin_speed[23:0], turn_rate[47:24], elapsed[63:48]
    input  logic         s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x_out[31:0], pos_y_out[63:32], heading_out[82:64], quat_z[98:83],
    // quat_w[114:99], lin_speed_out[138:115], turn_rate_out[162:139], zero fill
    output logic [167:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    uoi_pkg::state_t state_reg, state_next;

    logic signed [31:0] sx_reg, sy_reg, px_reg, py_reg;
    logic signed [18:0] sh_reg, hd_reg;
    logic signed [23:0] spd_reg, rate_reg;
    logic               first_reg;
    logic [15:0]        dt_reg;
    logic signed [40:0] hacc_reg;
    logic signed [24:0] hw_reg;
    logic signed [31:0] comp_reg;
    logic               neg_reg;
    logic signed [31:0] sn_reg, cs_reg;
    logic [167:0]       out_reg;
    logic               mv_reg;
    logic               sel_y_reg;

    logic               cstart;
    logic signed [27:0] cangle;
    logic               cdone;
    logic signed [31:0] csin, ccos;

    uoi_cordic u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cstart), .angle(cangle),
        .done(cdone), .sin_out(csin), .cos_out(ccos)
    );

    logic s_acc, m_acc;
    assign s_tready  = (state_reg == uoi_pkg::ST_IDLE) && !mv_reg;
    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = out_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            uoi_pkg::ST_IDLE:
                if (s_acc && s_tuser == uoi_pkg::CmdTick && !first_reg)
                    state_next = uoi_pkg::ST_HEAD;
            uoi_pkg::ST_HEAD:    state_next = uoi_pkg::ST_WRAP;
            uoi_pkg::ST_WRAP:
                if (hw_reg <= 25'(uoi_pkg::HeadPi) && hw_reg >= -25'(uoi_pkg::HeadPi))
                    state_next = uoi_pkg::ST_C1_INIT;
            uoi_pkg::ST_C1_INIT: state_next = uoi_pkg::ST_C1_RUN;
            uoi_pkg::ST_C1_RUN:  if (cdone) state_next = uoi_pkg::ST_MUL_X;
            uoi_pkg::ST_MUL_X:   state_next = uoi_pkg::ST_MUL_Y;
            uoi_pkg::ST_MUL_Y:
                if (sel_y_reg) state_next = uoi_pkg::ST_C2_INIT;
            uoi_pkg::ST_C2_INIT: state_next = uoi_pkg::ST_C2_RUN;
            uoi_pkg::ST_C2_RUN:  if (cdone) state_next = uoi_pkg::ST_OUT;
            uoi_pkg::ST_OUT:     state_next = uoi_pkg::ST_IDLE;
            default:             state_next = uoi_pkg::ST_IDLE;
        endcase
    end

    // angle for the CORDIC: heading with quadrant fold, or half heading for the quaternion
    logic signed [27:0] a_full;
    logic               a_neg;
    always_comb begin
        cstart = (state_reg == uoi_pkg::ST_C1_INIT) || (state_reg == uoi_pkg::ST_C2_INIT);
        a_full = 28'(hd_reg) <<< 8;
        a_neg  = 1'b0;
        if (state_reg == uoi_pkg::ST_C2_INIT) begin
            cangle = 28'(hd_reg) <<< 7;
        end else if (a_full > uoi_pkg::AngHalfPi) begin
            cangle = a_full - uoi_pkg::AngPi; a_neg = 1'b1;
        end else if (a_full < -uoi_pkg::AngHalfPi) begin
            cangle = a_full + uoi_pkg::AngPi; a_neg = 1'b1;
        end else begin
            cangle = a_full;
        end
    end

    // position step: comp = round(speed*trig/2^30), step = round(comp*dt/2^16)
    logic signed [55:0] pm;
    logic signed [48:0] sm;
    logic signed [32:0] step;
    logic signed [33:0] psum;
    logic signed [31:0] psat, trig;
    always_comb begin
        trig = sel_y_reg ? sn_reg : cs_reg;
        pm   = 56'(spd_reg) * 56'(trig);
        sm   = 49'(comp_reg) * $signed({1'b0, dt_reg});
        step = 33'((sm + 49'sd32768) >>> 16);
        psum = 34'(sel_y_reg ? py_reg : px_reg) + 34'(step);
        if (psum > 34'sd2147483647)       psat = 32'sh7fffffff;
        else if (psum < -34'sd2147483648) psat = 32'sh80000000;
        else                              psat = psum[31:0];
    end

    logic signed [31:0] qs_r, qc_r;
    logic signed [15:0] qz, qw;
    always_comb begin
        qs_r = (csin + 32'sd16384) >>> 15;
        qc_r = (ccos + 32'sd16384) >>> 15;
        qz = (qs_r > 32'sd32767) ? 16'sd32767 : (qs_r < -32'sd32767) ? -16'sd32767 : qs_r[15:0];
        qw = (qc_r > 32'sd32767) ? 16'sd32767 : (qc_r < -32'sd32767) ? -16'sd32767 : qc_r[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= uoi_pkg::ST_IDLE;
            mv_reg    <= 1'b0;
            first_reg <= 1'b1;
            sx_reg    <= -32'sd858843;
            sy_reg    <= 32'sd172738;
            sh_reg    <= -19'sd105031;
            px_reg    <= -32'sd858843;
            py_reg    <= 32'sd172738;
            hd_reg    <= -19'sd105031;
            spd_reg   <= '0;
            rate_reg  <= '0;
            sel_y_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_acc) mv_reg <= 1'b0;
            if (cfg_valid) begin
                case (cfg_index)
                    uoi_pkg::RegStartX: begin
                        sx_reg <= cfg_data; if (first_reg) px_reg <= cfg_data;
                    end
                    uoi_pkg::RegStartY: begin
                        sy_reg <= cfg_data; if (first_reg) py_reg <= cfg_data;
                    end
                    uoi_pkg::RegStartH: begin
                        sh_reg <= cfg_data[18:0];
                        if (first_reg) hd_reg <= cfg_data[18:0];
                    end
                    default: ;
                endcase
            end
            if (s_acc) begin
                dt_reg <= s_tdata[63:48];
                if (s_tuser == uoi_pkg::CmdVel) begin
                    spd_reg  <= s_tdata[23:0];
                    rate_reg <= s_tdata[47:24];
                end else if (first_reg) begin
                    first_reg <= 1'b0;
                end else begin
                    hacc_reg <= 41'(rate_reg) * $signed({1'b0, s_tdata[63:48]});
                end
            end
            case (state_reg)
                uoi_pkg::ST_HEAD:
                    hw_reg <= 25'(hd_reg) + 25'((hacc_reg + 41'sd32768) >>> 16);
                uoi_pkg::ST_WRAP:
                    if (hw_reg > 25'(uoi_pkg::HeadPi))
                        hw_reg <= hw_reg - 25'(uoi_pkg::HeadTwoPi);
                    else if (hw_reg < -25'(uoi_pkg::HeadPi))
                        hw_reg <= hw_reg + 25'(uoi_pkg::HeadTwoPi);
                    else
                        hd_reg <= hw_reg[18:0];
                uoi_pkg::ST_C1_INIT: begin
                    neg_reg   <= a_neg;
                    sel_y_reg <= 1'b0;
                end
                uoi_pkg::ST_C1_RUN:
                    if (cdone) begin
                        sn_reg <= neg_reg ? -csin : csin;
                        cs_reg <= neg_reg ? -ccos : ccos;
                    end
                uoi_pkg::ST_MUL_X:
                    comp_reg <= 32'((pm + 56'sd536870912) >>> 30);
                uoi_pkg::ST_MUL_Y: begin
                    if (sel_y_reg) py_reg <= psat;
                    else           px_reg <= psat;
                    sel_y_reg <= !sel_y_reg;
                    if (!sel_y_reg) comp_reg <= 32'((56'(spd_reg) * 56'(sn_reg)
                                                  + 56'sd536870912) >>> 30);
                end
                uoi_pkg::ST_C2_RUN:
                    if (cdone) begin
                        out_reg <= {5'd0, rate_reg, spd_reg, qw, qz, hd_reg, py_reg, px_reg};
                    end
                uoi_pkg::ST_OUT: mv_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    logic unused_ok;
    assign unused_ok = ^{sx_reg, sy_reg, sh_reg};

`ifndef SYNTHESIS
    a_busy_noin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != uoi_pkg::ST_IDLE) |-> !s_tready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_head_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == uoi_pkg::ST_OUT) |-> (hd_reg <= 19'sd205887 && hd_reg >= -19'sd205887))
        else $error("heading not wrapped");
`endif
endmodule

FILE: verif/unicycle_odometry_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// unicycle_odometry_checker: pose prediction and result comparison
// Watches the command, config and result channels, keeps its own copy of the
// pose state, predicts each tick's pose word and compares it field by field.
// ---------------------------------------------------------------------------
module unicycle_odometry_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [63:0]  s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [167:0] m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output int           fail_count,
    output int           poses_pending
);

    // highest field first, so px lands in the lowest bits of the word
    typedef struct packed {
        logic signed [23:0] rate;
        logic signed [23:0] spd;
        logic signed [15:0] qw;
        logic signed [15:0] qz;
        logic signed [18:0] hd;
        logic signed [31:0] py;
        logic signed [31:0] px;
    } pose_t;

    pose_t pose_q[$];

    longint sx, sy, sh, px, py, hd, spd, rate;
    bit     fresh;

    function automatic longint rshift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint atan_val(int i);
        longint tab[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
            262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2};
        return tab[i];
    endfunction

    task automatic rotate(input longint ang, output longint sn, output longint cs);
        longint x, y, z, xs, ys;
        x = 652032874;
        y = 0;
        z = ang;
        for (int i = 0; i < uoi_pkg::CordicSteps && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_val(i);
            end else begin
                x += ys; y -= xs; z += atan_val(i);
            end
        end
        sn = y;
        cs = x;
    endtask

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic advance_pose(input longint dt);
        longint h, a, sn, cs, qs, qc;
        bit     flip;
        pose_t  p;
        h = hd + rshift(rate * dt, 16);
        if (h > 205887)
            h -= ((h - 205887 + 411775 - 1) / 411775) * 411775;
        else if (h < -205887)
            h += ((-205887 - h + 411775 - 1) / 411775) * 411775;
        hd = h;
        a = hd * 256;
        flip = 0;
        if (a > 26353589) begin
            a -= 52707179; flip = 1;
        end else if (a < -26353589) begin
            a += 52707179; flip = 1;
        end
        rotate(a, sn, cs);
        if (flip) begin
            sn = -sn; cs = -cs;
        end
        px = sat(px + rshift(rshift(spd * cs, 30) * dt, 16), -64'sd2147483648, 64'sd2147483647);
        py = sat(py + rshift(rshift(spd * sn, 30) * dt, 16), -64'sd2147483648, 64'sd2147483647);
        rotate(hd * 128, qs, qc);
        p.px   = 32'(px);
        p.py   = 32'(py);
        p.hd   = 19'(hd);
        p.qz   = 16'(sat(rshift(qs, 15), -32767, 32767));
        p.qw   = 16'(sat(rshift(qc, 15), -32767, 32767));
        p.spd  = 24'(spd);
        p.rate = 24'(rate);
        pose_q.push_back(p);
    endtask

    task automatic compare(input string nm, input longint e, input longint a);
        if (e != a) begin
            $error("%s mismatch: expected %0d actual %0d", nm, e, a);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        pose_t got, exp_p;
        if (!aresetn) begin
            sx = -858843; sy = 172738; sh = -105031;
            px = sx; py = sy; hd = sh;
            spd = 0; rate = 0; fresh = 1;
            fail_count = 0;
            pose_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    uoi_pkg::RegStartX: begin
                        sx = longint'(signed'(cfg_data));
                        if (fresh) px = sx;
                    end
                    uoi_pkg::RegStartY: begin
                        sy = longint'(signed'(cfg_data));
                        if (fresh) py = sy;
                    end
                    uoi_pkg::RegStartH: begin
                        sh = longint'(signed'(cfg_data[18:0]));
                        if (fresh) hd = sh;
                    end
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == uoi_pkg::CmdVel) begin
                    spd  = longint'(signed'(s_tdata[23:0]));
                    rate = longint'(signed'(s_tdata[47:24]));
                end else if (fresh) begin
                    fresh = 0;
                end else begin
                    advance_pose(longint'(s_tdata[63:48]));
                end
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[162:0];
                if (pose_q.size() == 0) begin
                    $error("result word with no pose expected");
                    fail_count++;
                end else begin
                    exp_p = pose_q.pop_front();
                    compare("pos_x_out", exp_p.px, got.px);
                    compare("pos_y_out", exp_p.py, got.py);
                    compare("heading_out", exp_p.hd, got.hd);
                    compare("quat_z", exp_p.qz, got.qz);
                    compare("quat_w", exp_p.qw, got.qw);
                    compare("lin_speed_out", exp_p.spd, got.spd);
                    compare("turn_rate_out", exp_p.rate, got.rate);
                end
            end
        end
        poses_pending = pose_q.size();
    end

endmodule

FILE: verif/unicycle_odometry_integrator_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// unicycle_odometry_integrator_top_tb: odometry integrator testbench
// Drives start registers, velocity and tick words with random idling and
// backpressure; the checker predicts and compares every pose word.
// ---------------------------------------------------------------------------
module unicycle_odometry_integrator_top_tb;

    localparam int WatchdogLimit = 20000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic         s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [167:0] m_tdata;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    int           fail_count;
    int           poses_pending;
    int           idle_pct = 18;
    bit           hold_sink = 0;
    int           quiet = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    unicycle_odometry_integrator_top u_dut (.*);

    unicycle_odometry_checker u_chk (.*);

    // receiver: random stalls, plus one long hold-off
    always @(negedge aclk) begin
        if (hold_sink)
            m_tready <= 0;
        else
            m_tready <= ($urandom_range(99) >= idle_pct);
    end

    initial begin
        wait (aresetn);
        repeat (300) @(posedge aclk);
        hold_sink = 1;
        repeat (400) @(posedge aclk);
        hold_sink = 0;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WatchdogLimit) begin
            $display("unicycle_odometry_integrator_top test failed");
            $finish;
        end
    end

    // called at a falling edge; valid stays high after the accept until the
    // next word or an idle cycle replaces it
    task automatic send_word(input logic kind, input logic [23:0] spd,
                             input logic [23:0] rate, input logic [15:0] dt);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= kind;
        s_tdata  <= {dt, rate, spd};
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        wait (poses_pending == 0);
        repeat (60) @(negedge aclk);
    endtask

    task automatic tick(input logic [15:0] dt);
        send_word(uoi_pkg::CmdTick, '0, '0, dt);
    endtask

    task automatic vel(input logic [23:0] spd, input logic [23:0] rate);
        send_word(uoi_pkg::CmdVel, spd, rate, '0);
    endtask

    task automatic random_word();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            vel(24'($urandom), 24'($urandom));
        else if (r < 40)
            vel(24'($urandom_range(2000) - 1000), 24'($urandom_range(400000) - 200000));
        else
            tick((r < 90) ? 16'($urandom_range(8000)) : 16'($urandom));
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: loads before first tick, extremes, zero elapsed
        write_reg(uoi_pkg::RegStartX, 32'h7fff_0000);
        write_reg(uoi_pkg::RegStartY, 32'h8000_0000);
        write_reg(uoi_pkg::RegStartH, 32'h0003_24bf);   // just above +pi
        write_reg(2'd3, 32'hdead_beef);                 // unmapped index
        cfg_valid <= 0;
        vel(24'h7fffff, 24'h7fffff);
        tick(16'hffff);                        // first tick only arms
        tick(16'hffff);
        tick(16'h0000);
        vel(24'h800000, 24'h800000);
        tick(16'hffff);
        tick(16'h0001);
        vel(24'h000000, 24'h000000);
        tick(16'h1234);
        vel(24'h010000, 24'h000000);
        tick(16'h8000);
        drain();
        // later writes change only the registers
        write_reg(uoi_pkg::RegStartX, 32'h8000_0000);
        write_reg(uoi_pkg::RegStartY, 32'h7fff_ffff);
        write_reg(uoi_pkg::RegStartH, 32'h0004_0000);
        cfg_valid <= 0;
        vel(24'h7fffff, 24'h032440);
        tick(16'hffff);
        tick(16'hffff);
        drain();

        idle_pct = 0;
        for (int i = 0; i < 250; i++) random_word();
        idle_pct = 18;
        drain();
        for (int i = 0; i < 880; i++) begin
            random_word();
            if (i == 500) drain();
        end

        drain();
        if (fail_count == 0)
            $display("unicycle_odometry_integrator_top test passed");
        else
            $display("unicycle_odometry_integrator_top test failed");
        $finish;
    end

endmodule
